// ===== rtl/core/bgol_pkg.sv =====
// Package for the bilinear grid offset lookup core.
// Fixed field widths, configuration register indexes and reset constants.
// No dependencies.
`default_nettype none

package bgol_pkg;

    typedef enum logic [1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_SCALE_X  = 2'd2,
        CFG_SCALE_Y  = 2'd3
    } cfg_index_t;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;

    localparam int POS_W  = 19;
    localparam int REL_W  = POS_W + 1;
    localparam int FACT_W = 24;
    localparam int PROD_W = REL_W + FACT_W;
    localparam int GINT_W = PROD_W - 32;
    localparam int FRAC_W = 16;
    localparam int HGT_W  = 16;
    localparam int IDX_W  = 3;
    localparam int LR_W   = 34;
    localparam int ACC_W  = 51;
    localparam int ZF_W   = ACC_W - 31;

    localparam logic [FACT_W-1:0]        SCALE_RESET = 24'd335544;
    localparam logic signed [ACC_W:0]    ACC_HALF    = (ACC_W+1)'(64'sd1 <<< 31);
    localparam logic signed [HGT_W-1:0]  Z_MAX       = 16'sh7FFF;
    localparam logic signed [HGT_W-1:0]  Z_MIN       = 16'sh8000;

endpackage

`default_nettype wire

// ===== rtl/core/bilinear_grid_offset_lookup_core.sv =====
// Bilinear grid offset lookup core: height grid store and query pipeline. Depends on bgol_pkg.
// Throughput: one item per cycle while busy is low; writes and queries may be freely interleaved.
// A query item passes six register stages (offset, multiply, clamp, grid read, edge blend,
// centre blend) and the output register before its result is strobed on done. Writes give no result.
// Reset: asynchronous; grid reads as zero, registers return to defaults, busy until the next clock.
`default_nettype none

module bilinear_grid_offset_lookup_core #(
    parameter int GRID_COLS = 8,
    parameter int GRID_ROWS = 8
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [bgol_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [bgol_pkg::CFG_DAT_W-1:0]         cfg_wdata,
    input  wire logic                                   start,
    output logic                                        busy,
    input  wire logic                                   kind,
    input  wire logic signed [bgol_pkg::POS_W-1:0]      pos_x,
    input  wire logic signed [bgol_pkg::POS_W-1:0]      pos_y,
    input  wire logic [bgol_pkg::IDX_W-1:0]             grid_col,
    input  wire logic [bgol_pkg::IDX_W-1:0]             grid_row,
    input  wire logic signed [bgol_pkg::HGT_W-1:0]      grid_height,
    output logic                                        done,
    output logic signed [bgol_pkg::HGT_W-1:0]           z_offset,
    output logic [bgol_pkg::IDX_W-1:0]                  cell_col,
    output logic [bgol_pkg::IDX_W-1:0]                  cell_row
);

    localparam int DEPTH  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CX_W   = $clog2(GRID_COLS);
    localparam int CY_W   = $clog2(GRID_ROWS);

    localparam logic signed [bgol_pkg::GINT_W-1:0] GX_MAX = bgol_pkg::GINT_W'(GRID_COLS - 1);
    localparam logic signed [bgol_pkg::GINT_W-1:0] GY_MAX = bgol_pkg::GINT_W'(GRID_ROWS - 1);
    localparam logic [CX_W-1:0] CX_LAST = CX_W'(GRID_COLS - 1);
    localparam logic [CY_W-1:0] CY_LAST = CY_W'(GRID_ROWS - 1);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [CY_W-1:0] row,
                                                    input logic [CX_W-1:0] col);
        cell_addr = ADDR_W'(32'(row) * GRID_COLS + 32'(col));
    endfunction

    // configuration registers
    logic signed [bgol_pkg::POS_W-1:0]  origin_x_reg;
    logic signed [bgol_pkg::POS_W-1:0]  origin_y_reg;
    logic [bgol_pkg::FACT_W-1:0]        scale_x_reg;
    logic [bgol_pkg::FACT_W-1:0]        scale_y_reg;
    logic                               busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_x_reg  <= bgol_pkg::SCALE_RESET;
            scale_y_reg  <= bgol_pkg::SCALE_RESET;
            busy_reg     <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                unique case (bgol_pkg::cfg_index_t'(cfg_index))
                    bgol_pkg::CFG_ORIGIN_X: origin_x_reg <= cfg_wdata[bgol_pkg::POS_W-1:0];
                    bgol_pkg::CFG_ORIGIN_Y: origin_y_reg <= cfg_wdata[bgol_pkg::POS_W-1:0];
                    bgol_pkg::CFG_SCALE_X:  scale_x_reg  <= cfg_wdata;
                    bgol_pkg::CFG_SCALE_Y:  scale_y_reg  <= cfg_wdata;
                endcase
            end
        end
    end

    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // stage 1: offset from origin, write decode
    logic                               s1_qry_reg, s1_wr_reg;
    logic signed [bgol_pkg::REL_W-1:0]  s1_rel_x_reg, s1_rel_y_reg;
    logic [ADDR_W-1:0]                  s1_waddr_reg;
    logic signed [bgol_pkg::HGT_W-1:0]  s1_wdata_reg;
    logic                               wr_in_grid;

    assign wr_in_grid = (32'(grid_col) < GRID_COLS) && (32'(grid_row) < GRID_ROWS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_qry_reg <= 1'b0;
            s1_wr_reg  <= 1'b0;
        end
        else
        begin
            s1_qry_reg <= accept && kind;
            s1_wr_reg  <= accept && !kind && wr_in_grid;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_rel_x_reg <= bgol_pkg::REL_W'(pos_x) - bgol_pkg::REL_W'(origin_x_reg);
        s1_rel_y_reg <= bgol_pkg::REL_W'(pos_y) - bgol_pkg::REL_W'(origin_y_reg);
        s1_waddr_reg <= ADDR_W'(32'(grid_row) * GRID_COLS + 32'(grid_col));
        s1_wdata_reg <= grid_height;
    end

    // stage 2: scale to cells, 32 fraction bits
    logic                                s2_qry_reg, s2_wr_reg;
    logic signed [bgol_pkg::PROD_W-1:0]  s2_p_x_reg, s2_p_y_reg;
    logic [ADDR_W-1:0]                   s2_waddr_reg;
    logic signed [bgol_pkg::HGT_W-1:0]   s2_wdata_reg;
    logic signed [bgol_pkg::PROD_W:0]    p_x_next, p_y_next;

    assign p_x_next = s1_rel_x_reg * $signed({1'b0, scale_x_reg});
    assign p_y_next = s1_rel_y_reg * $signed({1'b0, scale_y_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_qry_reg <= 1'b0;
            s2_wr_reg  <= 1'b0;
        end
        else
        begin
            s2_qry_reg <= s1_qry_reg;
            s2_wr_reg  <= s1_wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_p_x_reg   <= bgol_pkg::PROD_W'(p_x_next);
        s2_p_y_reg   <= bgol_pkg::PROD_W'(p_y_next);
        s2_waddr_reg <= s1_waddr_reg;
        s2_wdata_reg <= s1_wdata_reg;
    end

    // stage 3: floor, clamp, fraction
    logic signed [bgol_pkg::GINT_W-1:0] gx_raw, gy_raw;
    logic                               x_neg, x_over, y_neg, y_over;
    logic [CX_W-1:0]                    gx_next, nx_next;
    logic [CY_W-1:0]                    gy_next, ny_next;
    logic [bgol_pkg::FRAC_W-1:0]        tx_next, ty_next;

    assign gx_raw = s2_p_x_reg[bgol_pkg::PROD_W-1:32];
    assign gy_raw = s2_p_y_reg[bgol_pkg::PROD_W-1:32];
    assign x_neg  = gx_raw[bgol_pkg::GINT_W-1];
    assign y_neg  = gy_raw[bgol_pkg::GINT_W-1];
    assign x_over = gx_raw > GX_MAX;
    assign y_over = gy_raw > GY_MAX;

    always_comb
    begin
        priority if (x_neg)
        begin
            gx_next = '0;
            tx_next = '0;
        end
        else if (x_over)
        begin
            gx_next = CX_LAST;
            tx_next = '1;
        end
        else
        begin
            gx_next = gx_raw[CX_W-1:0];
            tx_next = s2_p_x_reg[31:16];
        end
        priority if (y_neg)
        begin
            gy_next = '0;
            ty_next = '0;
        end
        else if (y_over)
        begin
            gy_next = CY_LAST;
            ty_next = '1;
        end
        else
        begin
            gy_next = gy_raw[CY_W-1:0];
            ty_next = s2_p_y_reg[31:16];
        end
        // last cell: next index holds
        nx_next = (gx_next == CX_LAST) ? gx_next : CX_W'(gx_next + 1'b1);
        ny_next = (gy_next == CY_LAST) ? gy_next : CY_W'(gy_next + 1'b1);
    end

    logic                               s3_qry_reg, s3_wr_reg;
    logic [CX_W-1:0]                    s3_gx_reg, s3_nx_reg;
    logic [CY_W-1:0]                    s3_gy_reg, s3_ny_reg;
    logic [bgol_pkg::FRAC_W-1:0]        s3_tx_reg, s3_ty_reg;
    logic [ADDR_W-1:0]                  s3_waddr_reg;
    logic signed [bgol_pkg::HGT_W-1:0]  s3_wdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_qry_reg <= 1'b0;
            s3_wr_reg  <= 1'b0;
        end
        else
        begin
            s3_qry_reg <= s2_qry_reg;
            s3_wr_reg  <= s2_wr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s3_gx_reg    <= gx_next;
        s3_nx_reg    <= nx_next;
        s3_gy_reg    <= gy_next;
        s3_ny_reg    <= ny_next;
        s3_tx_reg    <= tx_next;
        s3_ty_reg    <= ty_next;
        s3_waddr_reg <= s2_waddr_reg;
        s3_wdata_reg <= s2_wdata_reg;
    end

    // stage 4: grid read, two copies with two read ports each; writes land here too
    logic [ADDR_W-1:0] a00, a01, a10, a11;

    assign a00 = cell_addr(s3_gy_reg, s3_gx_reg);
    assign a01 = cell_addr(s3_ny_reg, s3_gx_reg);
    assign a10 = cell_addr(s3_gy_reg, s3_nx_reg);
    assign a11 = cell_addr(s3_ny_reg, s3_nx_reg);

    logic signed [bgol_pkg::HGT_W-1:0] grid_a [DEPTH];
    logic signed [bgol_pkg::HGT_W-1:0] grid_b [DEPTH];
    logic [DEPTH-1:0]                  entry_vld_reg;

    logic signed [bgol_pkg::HGT_W-1:0] s4_rd00_reg, s4_rd01_reg, s4_rd10_reg, s4_rd11_reg;
    logic                              s4_v00_reg, s4_v01_reg, s4_v10_reg, s4_v11_reg;
    logic                              s4_qry_reg;
    logic [CX_W-1:0]                   s4_gx_reg;
    logic [CY_W-1:0]                   s4_gy_reg;
    logic [bgol_pkg::FRAC_W-1:0]       s4_tx_reg, s4_ty_reg;

    always_ff @(posedge clk)
    begin
        if (s3_wr_reg)
        begin
            grid_a[s3_waddr_reg] <= s3_wdata_reg;
        end
        s4_rd00_reg <= grid_a[a00];
        s4_rd01_reg <= grid_a[a01];
    end

    always_ff @(posedge clk)
    begin
        if (s3_wr_reg)
        begin
            grid_b[s3_waddr_reg] <= s3_wdata_reg;
        end
        s4_rd10_reg <= grid_b[a10];
        s4_rd11_reg <= grid_b[a11];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_vld_reg <= '0;
            s4_qry_reg    <= 1'b0;
        end
        else
        begin
            if (s3_wr_reg)
            begin
                entry_vld_reg[s3_waddr_reg] <= 1'b1;
            end
            s4_qry_reg <= s3_qry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s4_v00_reg <= entry_vld_reg[a00];
        s4_v01_reg <= entry_vld_reg[a01];
        s4_v10_reg <= entry_vld_reg[a10];
        s4_v11_reg <= entry_vld_reg[a11];
        s4_gx_reg  <= s3_gx_reg;
        s4_gy_reg  <= s3_gy_reg;
        s4_tx_reg  <= s3_tx_reg;
        s4_ty_reg  <= s3_ty_reg;
    end

    // stage 5: blend along Y on both edges
    logic signed [bgol_pkg::HGT_W-1:0]   z00, z01, z10, z11;
    logic signed [bgol_pkg::HGT_W:0]     dl, dr;
    logic signed [bgol_pkg::FRAC_W:0]    ty_s;
    logic signed [bgol_pkg::LR_W-1:0]    lft_next, rgt_next;

    assign z00  = s4_v00_reg ? s4_rd00_reg : '0;
    assign z01  = s4_v01_reg ? s4_rd01_reg : '0;
    assign z10  = s4_v10_reg ? s4_rd10_reg : '0;
    assign z11  = s4_v11_reg ? s4_rd11_reg : '0;
    assign dl   = (bgol_pkg::HGT_W+1)'(z01) - (bgol_pkg::HGT_W+1)'(z00);
    assign dr   = (bgol_pkg::HGT_W+1)'(z11) - (bgol_pkg::HGT_W+1)'(z10);
    assign ty_s = $signed({1'b0, s4_ty_reg});
    assign lft_next = (bgol_pkg::LR_W'(z00) <<< 16) + bgol_pkg::LR_W'(dl * ty_s);
    assign rgt_next = (bgol_pkg::LR_W'(z10) <<< 16) + bgol_pkg::LR_W'(dr * ty_s);

    logic                              s5_qry_reg;
    logic signed [bgol_pkg::LR_W-1:0]  s5_lft_reg, s5_rgt_reg;
    logic [CX_W-1:0]                   s5_gx_reg;
    logic [CY_W-1:0]                   s5_gy_reg;
    logic [bgol_pkg::FRAC_W-1:0]       s5_tx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_qry_reg <= 1'b0;
        end
        else
        begin
            s5_qry_reg <= s4_qry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s5_lft_reg <= lft_next;
        s5_rgt_reg <= rgt_next;
        s5_gx_reg  <= s4_gx_reg;
        s5_gy_reg  <= s4_gy_reg;
        s5_tx_reg  <= s4_tx_reg;
    end

    // stage 6: blend along X
    logic signed [bgol_pkg::LR_W:0]     drl;
    logic signed [bgol_pkg::FRAC_W:0]   tx_s;
    logic signed [bgol_pkg::ACC_W-1:0]  acc_next;

    assign drl  = (bgol_pkg::LR_W+1)'(s5_rgt_reg) - (bgol_pkg::LR_W+1)'(s5_lft_reg);
    assign tx_s = $signed({1'b0, s5_tx_reg});
    assign acc_next = (bgol_pkg::ACC_W'(s5_lft_reg) <<< 16) + bgol_pkg::ACC_W'(drl * tx_s);

    logic                               s6_qry_reg;
    logic signed [bgol_pkg::ACC_W-1:0]  s6_acc_reg;
    logic [CX_W-1:0]                    s6_gx_reg;
    logic [CY_W-1:0]                    s6_gy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s6_qry_reg <= 1'b0;
        end
        else
        begin
            s6_qry_reg <= s5_qry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s6_acc_reg <= acc_next;
        s6_gx_reg  <= s5_gx_reg;
        s6_gy_reg  <= s5_gy_reg;
    end

    // output: round half up, saturate
    logic signed [bgol_pkg::ACC_W:0]    rnd_sum;
    logic signed [bgol_pkg::ZF_W-1:0]   z_full;
    logic signed [bgol_pkg::HGT_W-1:0]  z_next;

    assign rnd_sum = (bgol_pkg::ACC_W+1)'(s6_acc_reg) + bgol_pkg::ACC_HALF;
    assign z_full  = bgol_pkg::ZF_W'(rnd_sum >>> 32);

    always_comb
    begin
        priority if (z_full > bgol_pkg::ZF_W'(bgol_pkg::Z_MAX))
        begin
            z_next = bgol_pkg::Z_MAX;
        end
        else if (z_full < bgol_pkg::ZF_W'(bgol_pkg::Z_MIN))
        begin
            z_next = bgol_pkg::Z_MIN;
        end
        else
        begin
            z_next = z_full[bgol_pkg::HGT_W-1:0];
        end
    end

    logic                               done_reg;
    logic signed [bgol_pkg::HGT_W-1:0]  z_offset_reg;
    logic [bgol_pkg::IDX_W-1:0]         cell_col_reg, cell_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s6_qry_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        z_offset_reg <= z_next;
        cell_col_reg <= bgol_pkg::IDX_W'(s6_gx_reg);
        cell_row_reg <= bgol_pkg::IDX_W'(s6_gy_reg);
    end

    assign done     = done_reg;
    assign z_offset = z_offset_reg;
    assign cell_col = cell_col_reg;
    assign cell_row = cell_row_reg;

`ifndef SYNTH
    a_item_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##7 (done == $past(kind, 7)))
        else $error("result strobe does not match the kind of the item accepted earlier");

    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        s3_qry_reg |-> (({1'b0, s3_nx_reg} == ({1'b0, s3_gx_reg} + 1'b1)) ||
                        (s3_nx_reg == s3_gx_reg && s3_gx_reg == CX_LAST)))
        else $error("next column index is not current plus one or held at the last cell");

    a_below_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_qry_reg && x_neg) |=> (s3_gx_reg == '0 && s3_tx_reg == '0))
        else $error("position below the X origin did not clamp to cell zero");

    a_no_write_query_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(s3_wr_reg && s3_qry_reg))
        else $error("grid write and query in the same stage");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for bilinear_grid_offset_lookup_core: grid writes and offset queries.
// Predicts each query offset in step with the accepted items and checks every strobed result.
// Depends on bgol_pkg and the core RTL.

module testbench;

    localparam int GRID_COLS   = 8;
    localparam int GRID_ROWS   = 8;
    localparam int PIPE_CYCLES = 7;
    localparam int CYCLE_LIMIT = 200000;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct {
        logic                              kind;
        logic signed [bgol_pkg::POS_W-1:0] px;
        logic signed [bgol_pkg::POS_W-1:0] py;
        logic [bgol_pkg::IDX_W-1:0]        col;
        logic [bgol_pkg::IDX_W-1:0]        row;
        logic signed [bgol_pkg::HGT_W-1:0] hgt;
    } lookup_item_t;

    typedef struct {
        logic signed [bgol_pkg::HGT_W-1:0] z;
        logic [bgol_pkg::IDX_W-1:0]        col;
        logic [bgol_pkg::IDX_W-1:0]        row;
    } offset_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [bgol_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [bgol_pkg::CFG_DAT_W-1:0]    cfg_wdata = '0;
    logic                              start = 1'b0;
    logic                              busy;
    logic                              kind = 1'b0;
    logic signed [bgol_pkg::POS_W-1:0] pos_x = '0;
    logic signed [bgol_pkg::POS_W-1:0] pos_y = '0;
    logic [bgol_pkg::IDX_W-1:0]        grid_col = '0;
    logic [bgol_pkg::IDX_W-1:0]        grid_row = '0;
    logic signed [bgol_pkg::HGT_W-1:0] grid_height = '0;
    logic                              done;
    logic signed [bgol_pkg::HGT_W-1:0] z_offset;
    logic [bgol_pkg::IDX_W-1:0]        cell_col;
    logic [bgol_pkg::IDX_W-1:0]        cell_row;

    // predictor state
    longint                            org_x = 0;
    longint                            org_y = 0;
    longint                            scale_x = longint'(bgol_pkg::SCALE_RESET);
    longint                            scale_y = longint'(bgol_pkg::SCALE_RESET);
    logic signed [bgol_pkg::HGT_W-1:0] grid_heights [GRID_COLS*GRID_ROWS];

    offset_result_t pending_offsets[$];
    offset_result_t oldest;

    int  error_count = 0;
    int  checked_count = 0;
    int  query_count = 0;
    int  write_count = 0;
    int  config_count = 0;
    int  cycle_count = 0;
    bit  gaps_on = 1'b1;

    bilinear_grid_offset_lookup_core #(
        .GRID_COLS (GRID_COLS),
        .GRID_ROWS (GRID_ROWS)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .grid_col    (grid_col),
        .grid_row    (grid_row),
        .grid_height (grid_height),
        .done        (done),
        .z_offset    (z_offset),
        .cell_col    (cell_col),
        .cell_row    (cell_row)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // cell index, next index and 16-bit fraction along one axis
    function automatic void locate_axis(input longint pos, input longint org,
                                        input longint factor, input longint size,
                                        output longint idx, output longint nxt,
                                        output longint frac);
        longint prod;
        longint cidx;
        longint rem;
        prod = (pos - org) * factor;
        cidx = prod >>> 32;
        if (cidx < 0)
            cidx = 0;
        if (cidx > size - 1)
            cidx = size - 1;
        rem = prod - (cidx <<< 32);
        if (rem < 0)
            rem = 0;
        frac = rem >>> 16;
        if (frac > 65535)
            frac = 65535;
        idx = cidx;
        nxt = (cidx + 1 < size) ? cidx + 1 : cidx;
    endfunction

    function automatic offset_result_t predict_offset(
        input logic signed [bgol_pkg::POS_W-1:0] px,
        input logic signed [bgol_pkg::POS_W-1:0] py);
        longint gx, nx, tx, gy, ny, ty;
        longint z00, z01, z10, z11, lft, rgt, acc, z;
        offset_result_t res;
        locate_axis(longint'(px), org_x, scale_x, GRID_COLS, gx, nx, tx);
        locate_axis(longint'(py), org_y, scale_y, GRID_ROWS, gy, ny, ty);
        z00 = grid_heights[gy * GRID_COLS + gx];
        z01 = grid_heights[ny * GRID_COLS + gx];
        z10 = grid_heights[gy * GRID_COLS + nx];
        z11 = grid_heights[ny * GRID_COLS + nx];
        lft = z00 * 65536 + (z01 - z00) * ty;
        rgt = z10 * 65536 + (z11 - z10) * ty;
        acc = lft * 65536 + tx * (rgt - lft);
        z = (acc + (64'sd1 <<< 31)) >>> 32;
        if (z > 32767)
            z = 32767;
        if (z < -32768)
            z = -32768;
        res.z   = bgol_pkg::HGT_W'(z);
        res.col = bgol_pkg::IDX_W'(gx);
        res.row = bgol_pkg::IDX_W'(gy);
        return res;
    endfunction

    function automatic lookup_item_t make_write(input int col, input int row, input int hgt);
        lookup_item_t it;
        it.kind = KIND_WRITE;
        it.px   = bgol_pkg::POS_W'($urandom);
        it.py   = bgol_pkg::POS_W'($urandom);
        it.col  = bgol_pkg::IDX_W'(col);
        it.row  = bgol_pkg::IDX_W'(row);
        it.hgt  = bgol_pkg::HGT_W'(hgt);
        return it;
    endfunction

    function automatic lookup_item_t make_query(input longint x, input longint y);
        lookup_item_t it;
        it.kind = KIND_QUERY;
        it.px   = bgol_pkg::POS_W'(x);
        it.py   = bgol_pkg::POS_W'(y);
        it.col  = bgol_pkg::IDX_W'($urandom);
        it.row  = bgol_pkg::IDX_W'($urandom);
        it.hgt  = bgol_pkg::HGT_W'($urandom);
        return it;
    endfunction

    // mostly on or near the grid, otherwise anywhere
    function automatic longint pick_pos(input longint org, input longint scale, input int size);
        longint span;
        longint v;
        if ($urandom_range(0, 9) < 6 && scale != 0)
        begin
            span = (longint'(size) <<< 32) / scale;
            if (span > 600000)
                span = 600000;
            v = org - 2048 + longint'($urandom_range(0, int'(span) + 4096));
        end
        else
            v = longint'($signed(bgol_pkg::POS_W'($urandom)));
        if (v > 262143)
            v = 262143;
        if (v < -262144)
            v = -262144;
        return v;
    endfunction

    function automatic int pick_height();
        case ($urandom_range(0, 7))
            0:       return 32767;
            1:       return -32768;
            default: return int'($signed(bgol_pkg::HGT_W'($urandom)));
        endcase
    endfunction

    task automatic send_item(input lookup_item_t it);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        kind        <= it.kind;
        pos_x       <= it.px;
        pos_y       <= it.py;
        grid_col    <= it.col;
        grid_row    <= it.row;
        grid_height <= it.hgt;
        start       <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (it.kind == KIND_QUERY)
        begin
            pending_offsets.push_back(predict_offset(it.px, it.py));
            query_count++;
        end
        else
        begin
            if (it.col < GRID_COLS && it.row < GRID_ROWS)
                grid_heights[int'(it.row) * GRID_COLS + int'(it.col)] = it.hgt;
            write_count++;
        end
    endtask

    task automatic drain_pipeline();
        start <= 1'b0;
        @(posedge clk);
        while (pending_offsets.size() != 0)
            @(posedge clk);
        // writes leave no result, so give them time to land
        repeat (PIPE_CYCLES + 5) @(posedge clk);
    endtask

    task automatic write_reg(input bgol_pkg::cfg_index_t idx,
                             input logic [bgol_pkg::CFG_DAT_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            bgol_pkg::CFG_ORIGIN_X: org_x   = longint'($signed(data[bgol_pkg::POS_W-1:0]));
            bgol_pkg::CFG_ORIGIN_Y: org_y   = longint'($signed(data[bgol_pkg::POS_W-1:0]));
            bgol_pkg::CFG_SCALE_X:  scale_x = longint'(data);
            bgol_pkg::CFG_SCALE_Y:  scale_y = longint'(data);
            default: ;
        endcase
    endtask

    task automatic load_config(input longint ox, input longint oy,
                               input longint sx, input longint sy);
        write_reg(bgol_pkg::CFG_ORIGIN_X, bgol_pkg::CFG_DAT_W'(ox));
        write_reg(bgol_pkg::CFG_ORIGIN_Y, bgol_pkg::CFG_DAT_W'(oy));
        write_reg(bgol_pkg::CFG_SCALE_X, bgol_pkg::CFG_DAT_W'(sx));
        write_reg(bgol_pkg::CFG_SCALE_Y, bgol_pkg::CFG_DAT_W'(sy));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        config_count++;
    endtask

    task automatic run_mixed(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 30)
                send_item(make_write($urandom_range(0, GRID_COLS - 1),
                                     $urandom_range(0, GRID_ROWS - 1), pick_height()));
            else
                send_item(make_query(pick_pos(org_x, scale_x, GRID_COLS),
                                     pick_pos(org_y, scale_y, GRID_ROWS)));
        end
    endtask

    task automatic load_random_config();
        load_config(-longint'($urandom_range(0, 150000)), -longint'($urandom_range(0, 150000)),
                    $urandom_range(200000, 700000), $urandom_range(200000, 700000));
    endtask

    // corners, edges and saturating heights at the reset grid spacing (12800 per cell)
    task automatic test_directed();
        send_item(make_query(0, 0));
        send_item(make_query(-262144, -262144));
        send_item(make_write(0, 0, 32767));
        send_item(make_write(1, 0, -32768));
        send_item(make_write(0, 1, -32768));
        send_item(make_write(1, 1, 32767));
        send_item(make_write(7, 7, 32767));
        send_item(make_write(6, 7, -32768));
        send_item(make_write(7, 6, 12345));
        send_item(make_write(6, 6, -1));
        send_item(make_query(0, 0));
        send_item(make_query(6400, 6400));
        send_item(make_query(12799, 3200));
        send_item(make_query(-1, 100));
        send_item(make_query(262143, 262143));
        send_item(make_query(262143, 83200));
        send_item(make_query(83200, 262143));
        send_item(make_query(89599, 89599));
        send_item(make_query(89600, 89600));
        send_item(make_write(3, 4, -32768));
        send_item(make_write(3, 4, 21));
        send_item(make_query(38400, 51200));
        send_item(make_query(-262144, 262143));
        drain_pipeline();
    endtask

    task automatic test_config_extremes();
        load_config(-262144, 262143, 0, 16777215);
        run_mixed(15);
        drain_pipeline();
        load_config(262143, -262144, 16777215, 0);
        run_mixed(15);
        drain_pipeline();
        load_config(0, 0, 16777215, 16777215);
        run_mixed(15);
        drain_pipeline();
        load_config(-262144, -262144, 1, 1);
        run_mixed(15);
        drain_pipeline();
    endtask

    task automatic test_random_gaps();
        load_random_config();
        run_mixed(120);
        drain_pipeline();
        run_mixed(120);
        drain_pipeline();
        load_random_config();
        run_mixed(240);
        drain_pipeline();
    endtask

    task automatic test_streaming();
        load_config(0, 0, bgol_pkg::SCALE_RESET, bgol_pkg::SCALE_RESET);
        gaps_on = 1'b0;
        run_mixed(240);
        drain_pipeline();
    endtask

    initial
    begin
        foreach (grid_heights[i])
            grid_heights[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_extremes();
        test_random_gaps();
        test_streaming();
        $display("Covered %0d queries and %0d grid writes across %0d register settings.",
                 query_count, write_count, config_count);
        $display("%0d offsets compared, with sender gaps, full drains and a gap-free stretch.",
                 checked_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_offsets.size() == 0)
            begin
                $error("unexpected result: z_offset %0d cell_col %0d cell_row %0d",
                       z_offset, cell_col, cell_row);
                error_count++;
            end
            else
            begin
                oldest = pending_offsets.pop_front();
                checked_count++;
                if (z_offset !== oldest.z)
                begin
                    $error("z_offset: expected %0d, got %0d", oldest.z, z_offset);
                    error_count++;
                end
                if (cell_col !== oldest.col)
                begin
                    $error("cell_col: expected %0d, got %0d", oldest.col, cell_col);
                    error_count++;
                end
                if (cell_row !== oldest.row)
                begin
                    $error("cell_row: expected %0d, got %0d", oldest.row, cell_row);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d offsets outstanding.",
                     cycle_count, pending_offsets.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
